// ----- design/gput_pkg.sv -----
package gput_pkg;

  // Item kinds
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Register map
  typedef enum logic [2:0] {
    REG_CONTROL   = 3'd0,
    REG_IRQ_EN    = 3'd1,
    REG_STATUS    = 3'd2,
    REG_PRESCALER = 3'd3,
    REG_RELOAD    = 3'd4,
    REG_COUNTER   = 3'd5
  } reg_index_t;

  localparam int DATA_WIDTH = 16;
  localparam int CTL_WIDTH  = 4;

  // Control register bit positions
  localparam int CTL_EN   = 0;
  localparam int CTL_OPM  = 1;
  localparam int CTL_DIR  = 2;
  localparam int CTL_ARPE = 3;

  typedef struct packed {
    logic                  valid;
    logic [1:0]            op;
    logic [2:0]            reg_index;
    logic [DATA_WIDTH-1:0] write_data;
  } step_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_data;
    logic                  irq_line;
    logic                  update_event;
  } result_t;

endpackage

// ----- design/gput_in_if.sv -----
interface gput_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [2:0]  reg_index;
  logic [15:0] write_data;

  modport source (output valid, output op, output reg_index, output write_data, input ready);
  modport sink   (input valid, input op, input reg_index, input write_data, output ready);
endinterface

// ----- design/gput_out_if.sv -----
interface gput_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        irq_line;
  logic        update_event;

  modport source (output valid, output read_data, output irq_line, output update_event,
                  input ready);
  modport sink   (input valid, input read_data, input irq_line, input update_event,
                  output ready);
endinterface

// ----- design/general_purpose_update_timer_core.sv -----
// Channel      Role    Payload                               Handshake
// item_in      sink    op, reg_index, write_data             valid/ready
// result_out   source  read_data, irq_line, update_event     valid/ready
//
// Each item is captured in the input register, executed against the timer
// registers when it advances out of that register, and its result lands in the
// output register. One item enters per cycle while result_out keeps up.
// Reset (rst, synchronous) stops the timer, clears flag, counts, prescaler
// and enables, and sets both reload copies to all ones.
// A stall on result_out holds the input register; item_in.ready drops only
// when both the input and output registers are full.
module general_purpose_update_timer_core
  import gput_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  gput_in_if.sink       item_in,
  gput_out_if.source    result_out
);

  // Input register
  logic                  in_valid;
  logic [1:0]            in_op;
  logic [2:0]            in_reg_index;
  logic [DATA_WIDTH-1:0] in_write_data;

  // Output register
  logic                  out_valid;
  logic [DATA_WIDTH-1:0] out_read_data;
  logic                  out_irq_line;
  logic                  out_update_event;

  logic    accept;
  logic    advance;
  step_t   step;
  result_t result;

  // Advance the held item when the output register is free or being drained
  assign advance       = in_valid && (!out_valid || result_out.ready);
  assign item_in.ready = !in_valid || advance;
  assign accept        = item_in.valid && item_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_op         <= item_in.op;
      in_reg_index  <= item_in.reg_index;
      in_write_data <= item_in.write_data;
    end
  end

  // Execute only on the cycle the item moves on, so state changes once per item
  assign step.valid      = advance;
  assign step.op         = in_op;
  assign step.reg_index  = in_reg_index;
  assign step.write_data = in_write_data;

  gput_regfile #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_regfile (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_read_data    <= result.read_data;
      out_irq_line     <= result.irq_line;
      out_update_event <= result.update_event;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.read_data    = out_read_data;
  assign result_out.irq_line     = out_irq_line;
  assign result_out.update_event = out_update_event;

endmodule

// ----- design/gput_regfile.sv -----
module gput_regfile
  import gput_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  step_t   step,
  output result_t result
);

  logic [COUNT_WIDTH-1:0] count_value, count_value_next;
  logic [DATA_WIDTH-1:0]  prescale_count, prescale_count_next;
  logic [DATA_WIDTH-1:0]  prescale_preload, prescale_preload_next;
  logic [DATA_WIDTH-1:0]  prescale_active, prescale_active_next;
  logic [COUNT_WIDTH-1:0] reload_preload, reload_preload_next;
  logic [COUNT_WIDTH-1:0] reload_active, reload_active_next;
  logic [CTL_WIDTH-1:0]   control_bits, control_bits_next;
  logic                   update_irq_enable, update_irq_enable_next;
  logic                   update_flag, update_flag_next;

  logic [COUNT_WIDTH+DATA_WIDTH-1:0] wdata_ext, count_ext, reload_ext;
  logic [COUNT_WIDTH-1:0]            wdata_cnt;
  logic [DATA_WIDTH-1:0]             read_data;
  logic                              update_event;

  // Fit write data and counter-wide values to the bus width
  assign wdata_ext  = {{COUNT_WIDTH{1'b0}}, step.write_data};
  assign wdata_cnt  = wdata_ext[COUNT_WIDTH-1:0];
  assign count_ext  = {{DATA_WIDTH{1'b0}}, count_value};
  assign reload_ext = {{DATA_WIDTH{1'b0}}, reload_preload};

  always_comb begin
    count_value_next       = count_value;
    prescale_count_next    = prescale_count;
    prescale_preload_next  = prescale_preload;
    prescale_active_next   = prescale_active;
    reload_preload_next    = reload_preload;
    reload_active_next     = reload_active;
    control_bits_next      = control_bits;
    update_irq_enable_next = update_irq_enable;
    update_flag_next       = update_flag;
    read_data              = '0;
    update_event           = 1'b0;

    if (step.valid) begin
      case (step.op)
        OP_TICK: begin
          if (control_bits[CTL_EN]) begin
            if (prescale_count < prescale_active) begin
              prescale_count_next = prescale_count + 1'b1;
            end else begin
              prescale_count_next = '0;
              if (!control_bits[CTL_DIR]) begin
                if (count_value < reload_active) begin
                  count_value_next = count_value + 1'b1;
                end else begin
                  count_value_next = '0;
                  update_event     = 1'b1;
                end
              end else begin
                if (count_value != '0) begin
                  count_value_next = count_value - 1'b1;
                end else begin
                  // Down wrap reloads from the value that becomes active now
                  count_value_next = reload_preload;
                  update_event     = 1'b1;
                end
              end
              if (update_event) begin
                update_flag_next     = 1'b1;
                prescale_active_next = prescale_preload;
                reload_active_next   = reload_preload;
                if (control_bits[CTL_OPM]) begin
                  control_bits_next[CTL_EN] = 1'b0;
                end
              end
            end
          end
        end
        OP_WRITE: begin
          case (step.reg_index)
            REG_CONTROL:   control_bits_next      = step.write_data[CTL_WIDTH-1:0];
            REG_IRQ_EN:    update_irq_enable_next = step.write_data[0];
            REG_STATUS: begin
              // Write zero to clear; a one leaves the flag alone
              if (!step.write_data[0]) begin
                update_flag_next = 1'b0;
              end
            end
            REG_PRESCALER: prescale_preload_next  = step.write_data;
            REG_RELOAD: begin
              reload_preload_next = wdata_cnt;
              if (!control_bits[CTL_ARPE]) begin
                reload_active_next = wdata_cnt;
              end
            end
            REG_COUNTER:   count_value_next       = wdata_cnt;
            default: ;
          endcase
        end
        OP_READ: begin
          case (step.reg_index)
            REG_CONTROL:   read_data = {{(DATA_WIDTH-CTL_WIDTH){1'b0}}, control_bits};
            REG_IRQ_EN:    read_data = {{(DATA_WIDTH-1){1'b0}}, update_irq_enable};
            REG_STATUS:    read_data = {{(DATA_WIDTH-1){1'b0}}, update_flag};
            REG_PRESCALER: read_data = prescale_preload;
            REG_RELOAD:    read_data = reload_ext[DATA_WIDTH-1:0];
            REG_COUNTER:   read_data = count_ext[DATA_WIDTH-1:0];
            default:       read_data = '0;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign result.read_data    = read_data;
  assign result.irq_line     = update_flag_next & update_irq_enable_next;
  assign result.update_event = update_event;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_value       <= '0;
      prescale_count    <= '0;
      prescale_preload  <= '0;
      prescale_active   <= '0;
      reload_preload    <= '1;
      reload_active     <= '1;
      control_bits      <= '0;
      update_irq_enable <= 1'b0;
      update_flag       <= 1'b0;
    end else begin
      count_value       <= count_value_next;
      prescale_count    <= prescale_count_next;
      prescale_preload  <= prescale_preload_next;
      prescale_active   <= prescale_active_next;
      reload_preload    <= reload_preload_next;
      reload_active     <= reload_active_next;
      control_bits      <= control_bits_next;
      update_irq_enable <= update_irq_enable_next;
      update_flag       <= update_flag_next;
    end
  end

endmodule
